// ===== hdl/tvg_pkg.sv =====
// Shared types, constants and tables of the torus vertex generator.
`default_nettype none
package tvg_pkg;

	// Angle resolution and CORDIC depth.
	localparam int ANGLE_BITS = 16;
	localparam int CORDIC_STEPS = 30;
	localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic [15:0] HALF_TURN = 16'h8000;

	// Pipeline depths: one phase stage, the CORDIC, and the scaling stages.
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;
	localparam int SCALE_LAT = 4;
	localparam int PIPE_LAT = 1 + CORDIC_LAT + SCALE_LAT;

	// Arctangent of 2^-i in turns times 2^32.
	localparam logic signed [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10680862, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772, 32'sd166886,
		32'sd83443, 32'sd41722, 32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608,
		32'sd1304, 32'sd652, 32'sd326, 32'sd163, 32'sd81, 32'sd41, 32'sd20,
		32'sd10, 32'sd5, 32'sd3, 32'sd1
	};

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_RING_COUNT = 3'd0,
		REG_SEGMENT_COUNT = 3'd1,
		REG_MAIN_RADIUS = 3'd2,
		REG_TUBE_RATIO = 3'd3,
		REG_SIDE_STEP = 3'd4,
		REG_SECTOR_STEP = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [9:0] ring_index;
		logic [9:0] segment_index;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic in_range;
	} out_item_t;

	// Radii handed to the scaling unit: tube in Q12.16, rad in Q8.16.
	typedef struct packed {
		logic [27:0] tube;
		logic [23:0] rad;
	} scale_cfg_t;

endpackage
`default_nettype wire

// ===== hdl/tvg_if.sv =====
// Valid/ready channels for index pairs and vertices.
`default_nettype none
interface tvg_in_if;
	logic valid;
	logic ready;
	tvg_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tvg_out_if;
	logic valid;
	logic ready;
	tvg_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/tvg_cordic.sv =====
// Pipelined CORDIC giving cosine and sine of a 32-bit turn angle in Q1.30.
`default_nettype none
module tvg_cordic (
	input wire logic clk,
	input wire logic en,
	input wire logic [31:0] angle,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);
	localparam int N = tvg_pkg::CORDIC_STEPS;

	logic signed [31:0] x_s [0:N];
	logic signed [31:0] y_s [0:N];
	logic signed [31:0] z_s [0:N];
	logic [1:0] q_s [0:N];

	// Load the start vector; the quadrant is folded back in at the end.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= tvg_pkg::CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= {2'b00, angle[29:0]};
			q_s[0] <= angle[31:30];
		end
	end

	// One rotation per stage.
	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= q_s[i];
				if (!z_s[i][31]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - tvg_pkg::ATAN_TURNS[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + tvg_pkg::ATAN_TURNS[i];
				end
			end
		end
	end

	// Quadrant correction.
	always_ff @(posedge clk) begin
		if (en) begin
			unique case (q_s[N])
				2'd0: begin cos_val <= x_s[N]; sin_val <= y_s[N]; end
				2'd1: begin cos_val <= -y_s[N]; sin_val <= x_s[N]; end
				2'd2: begin cos_val <= -x_s[N]; sin_val <= -y_s[N]; end
				default: begin cos_val <= y_s[N]; sin_val <= -x_s[N]; end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/tvg_scale.sv =====
// Scales the unit vectors by the radii, rounds and saturates the vertex, and zeroes it unless keep is set.
`default_nettype none
module tvg_scale (
	input wire logic clk,
	input wire logic en,
	input wire tvg_pkg::scale_cfg_t radii,
	input wire logic signed [31:0] cos_side,
	input wire logic signed [31:0] sin_side,
	input wire logic signed [31:0] cos_sector,
	input wire logic signed [31:0] sin_sector,
	input wire logic keep,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z
);
	localparam logic signed [63:0] HALF64 = 64'sd536870912;
	localparam logic signed [60:0] HALF61 = 61'sd536870912;

	logic signed [60:0] ring_p_s1;
	logic signed [31:0] cr_s1, sr_s1, ss_s1, cr_s2, sr_s2, ss_s2;
	logic signed [31:0] xy_s2;
	logic signed [60:0] ring_r;
	logic signed [63:0] px_s3, py_s3, pz_s3;
	logic signed [28:0] tube_sg;

	assign tube_sg = $signed({1'b0, radii.tube});
	assign ring_r = ring_p_s1 + HALF61;

	// Round a Q18.46 product to Q16.16 and clamp to 32 bits.
	function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
		logic signed [63:0] r;
		logic signed [33:0] v;
		r = p + HALF64;
		v = r[63:30];
		if (v > 34'sd2147483647) return 32'sh7fffffff;
		else if (v < -34'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction

	// Stage 1: tube times cosine of the side angle.
	always_ff @(posedge clk) begin
		if (en) begin
			ring_p_s1 <= tube_sg * cos_side;
			cr_s1 <= cos_sector;
			sr_s1 <= sin_sector;
			ss_s1 <= sin_side;
		end
	end

	// Stage 2: distance from the axis.
	always_ff @(posedge clk) begin
		if (en) begin
			xy_s2 <= 32'($signed(ring_r[60:30])) + $signed({8'b0, radii.rad});
			cr_s2 <= cr_s1;
			sr_s2 <= sr_s1;
			ss_s2 <= ss_s1;
		end
	end

	// Stage 3: the three coordinate products.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s3 <= xy_s2 * cr_s2;
			py_s3 <= xy_s2 * sr_s2;
			pz_s3 <= tube_sg * ss_s2;
		end
	end

	// Stage 4: round, saturate, and zero an out-of-range vertex.
	always_ff @(posedge clk) begin
		if (en) begin
			pos_x <= keep ? round_sat(px_s3) : '0;
			pos_y <= keep ? round_sat(py_s3) : '0;
			pos_z <= keep ? round_sat(pz_s3) : '0;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/torus_vertex_generator_core.sv =====
// Top level of the torus vertex generator.
//
// Channel in_item carries a ring index and a segment index; channel out_item
// returns one vertex per accepted item: pos_x, pos_y, pos_z in signed Q16.16,
// saturated, and in_range, which is low when ring_index > ring_count or
// segment_index >= segment_count (then the position is zero).
// Registers are written through cfg_we, cfg_index and cfg_data; unknown
// indexes are ignored. The user must write registers only while the block is
// idle; the block itself does not enforce this. An item passes 37 register
// stages: one phase stage, 32 stages of CORDIC (load, 30 rotations,
// quadrant), and four stages of multiply, add, multiply and round. One item
// enters every cycle unless out_item stalls.
// The whole pipeline advances together: when out_item holds a result that
// is not taken, every stage holds and in_item.ready drops; empty stages do
// not close up. Reset clears all valid bits and restores register defaults
// (32 rings, 32 segments, radius 1.0, ratio 0.5, steps 1/32 turn).
`default_nettype none
module torus_vertex_generator_core (
	input wire logic clk,
	input wire logic arst_n,
	tvg_in_if.sink in_item,
	tvg_out_if.source out_item,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	localparam int LAT = tvg_pkg::PIPE_LAT;

	logic [9:0] ring_count_q, segment_count_q;
	logic [15:0] main_radius_q, tube_ratio_q, side_step_q, sector_step_q;
	logic [27:0] tube_q;
	tvg_pkg::scale_cfg_t radii;
	logic adv;
	logic in_ok;
	logic [25:0] side_prod, sector_prod;
	logic [15:0] side_phase_s1, sector_phase_s1;
	logic vld_s [1:LAT];
	logic rng_s [1:LAT];
	logic signed [31:0] cs, ss, cr, sr;
	logic [31:0] tube_full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q <= 10'd32;
			segment_count_q <= 10'd32;
			main_radius_q <= 16'd256;
			tube_ratio_q <= 16'd2048;
			side_step_q <= 16'd2048;
			sector_step_q <= 16'd2048;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tvg_pkg::REG_RING_COUNT: ring_count_q <= cfg_data[9:0];
				tvg_pkg::REG_SEGMENT_COUNT: segment_count_q <= cfg_data[9:0];
				tvg_pkg::REG_MAIN_RADIUS: main_radius_q <= cfg_data;
				tvg_pkg::REG_TUBE_RATIO: tube_ratio_q <= cfg_data;
				tvg_pkg::REG_SIDE_STEP: side_step_q <= cfg_data;
				tvg_pkg::REG_SECTOR_STEP: sector_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The tube radius is registered and follows the registers in the next cycle.
	assign tube_full = main_radius_q * tube_ratio_q;
	always_ff @(posedge clk) begin
		tube_q <= 28'((33'(tube_full) + 33'd8) >> 4);
	end
	assign radii.tube = tube_q;
	assign radii.rad = {main_radius_q, 8'b0};

	// The pipeline moves unless a finished result is waiting and not taken.
	assign adv = !vld_s[LAT] || out_item.ready;
	assign in_item.ready = adv;

	assign in_ok = (in_item.data.ring_index <= ring_count_q)
		&& (in_item.data.segment_index < segment_count_q);
	assign side_prod = in_item.data.ring_index * side_step_q;
	assign sector_prod = in_item.data.segment_index * sector_step_q;

	// Stage 1: angle phases.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_phase_s1 <= tvg_pkg::HALF_TURN - side_prod[15:0];
			sector_phase_s1 <= sector_prod[15:0];
		end
	end

	// Valid and range flags travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) begin
				vld_s[k] <= 1'b0;
				rng_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= in_item.valid;
			rng_s[1] <= in_ok;
			for (int k = 2; k <= LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
				rng_s[k] <= rng_s[k-1];
			end
		end
	end

	tvg_cordic u_side (
		.clk(clk), .en(adv),
		.angle({side_phase_s1, 16'b0} & tvg_pkg::ANGLE_MASK),
		.cos_val(cs), .sin_val(ss)
	);

	tvg_cordic u_sector (
		.clk(clk), .en(adv),
		.angle({sector_phase_s1, 16'b0} & tvg_pkg::ANGLE_MASK),
		.cos_val(cr), .sin_val(sr)
	);

	tvg_scale u_scale (
		.clk(clk), .en(adv), .radii(radii),
		.cos_side(cs), .sin_side(ss), .cos_sector(cr), .sin_sector(sr),
		.keep(rng_s[LAT-1]),
		.pos_x(out_item.data.pos_x), .pos_y(out_item.data.pos_y),
		.pos_z(out_item.data.pos_z)
	);

	assign out_item.valid = vld_s[LAT];
	assign out_item.data.in_range = rng_s[LAT];

`ifndef SYNTHESIS
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_item.valid && !out_item.data.in_range) |->
		(out_item.data.pos_x == 0 && out_item.data.pos_y == 0
		&& out_item.data.pos_z == 0))
		else $error("out-of-range vertex is not zero");
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_item.valid && !out_item.ready) |-> !in_item.ready)
		else $error("input taken while output stalled");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_item.valid && in_item.ready) |=> vld_s[1])
		else $error("accepted item lost at pipeline entry");
`endif
endmodule
`default_nettype wire
